>>> rtl/jts_pkg.sv
// Shared types, byte codes and helper functions of the JSON token scanner.
// Used by jts_scan, jts_tok_fifo and json_token_scanner_top; depends on nothing.
package jts_pkg;

    localparam int POS_BITS    = 16;
    localparam int MAX_RESULTS = 3;
    localparam int NCAND       = 4;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    typedef logic [POS_BITS-1:0] pos_t;

    typedef enum logic [3:0] {
        TK_LBRACE   = 4'd0,
        TK_RBRACE   = 4'd1,
        TK_LBRACKET = 4'd2,
        TK_RBRACKET = 4'd3,
        TK_COLON    = 4'd4,
        TK_COMMA    = 4'd5,
        TK_STRING   = 4'd6,
        TK_INT      = 4'd7,
        TK_DOUBLE   = 4'd8,
        TK_TRUE     = 4'd9,
        TK_FALSE    = 4'd10,
        TK_NULL     = 4'd11,
        TK_UNKNOWN  = 4'd12,
        TK_EOF      = 4'd13
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_t;

    // Candidate tokens of one beat, in order: close at byte, byte's own token,
    // close at end of source, end-of-file marker.
    typedef struct packed {
        logic [NCAND-1:0]   vld;
        token_t [NCAND-1:0] tok;
    } tok_batch_t;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;

    localparam logic [2:0] KW_ALL = 3'b111;

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic pos_t sat_inc(pos_t v);
        return (v == {POS_BITS{1'b1}}) ? v : pos_t'(v + pos_t'(1));
    endfunction

    function automatic logic [15:0] sat16(pos_t v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic pos_t span(pos_t pos, pos_t first);
        return (pos >= first) ? pos_t'(pos - first) : '0;
    endfunction

    // Keyword 0 true, 1 false, 2 null
    function automatic logic [2:0] kw_len(logic [1:0] k);
        logic [2:0] r;
        case (k)
            2'd1:    r = 3'd5;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] idx);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            2'd0:
            begin
                case (idx)
                    3'd0:    r = 8'h74;
                    3'd1:    r = 8'h72;
                    3'd2:    r = 8'h75;
                    3'd3:    r = 8'h65;
                    default: r = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (idx)
                    3'd0:    r = 8'h66;
                    3'd1:    r = 8'h61;
                    3'd2:    r = 8'h6C;
                    3'd3:    r = 8'h73;
                    3'd4:    r = 8'h65;
                    default: r = 8'h00;
                endcase
            end
            2'd2:
            begin
                case (idx)
                    3'd0:    r = 8'h6E;
                    3'd1:    r = 8'h75;
                    3'd2:    r = 8'h6C;
                    3'd3:    r = 8'h6C;
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Drop every keyword candidate that the byte at word offset idx rules out
    function automatic logic [2:0] kw_feed(logic [2:0] m, logic [2:0] idx, logic [7:0] b);
        logic [2:0] r;
        r = m;
        for (int k = 0; k < 3; k++)
        begin
            if (m[k] && ((idx >= kw_len(2'(k))) || (kw_char(2'(k), idx) != b)))
                r[k] = 1'b0;
        end
        return r;
    endfunction

    function automatic tok_kind_t kw_kind(logic [2:0] m, logic [2:0] wlen);
        tok_kind_t r;
        r = TK_UNKNOWN;
        if (m[0] && (wlen == kw_len(2'd0)))
            r = TK_TRUE;
        if (m[1] && (wlen == kw_len(2'd1)))
            r = TK_FALSE;
        if (m[2] && (wlen == kw_len(2'd2)))
            r = TK_NULL;
        return r;
    endfunction

endpackage

>>> rtl/json_token_scanner_top.sv
// JSON token scanner: one source byte per beat in, tokens out.
// Input beat: tdata = src_byte, tuser = byte_present, tlast = source_end.
// Output beat: tdata = token_start, token_length; tuser = token_kind;
// tlast = final token caused by the input beat (last_of_run).
// A beat with byte_present low carries no byte; with tlast it only ends
// the source, and with neither it does nothing.
// The tokens of a beat are registered in the token queue and offered from
// its head. Throughput: one byte per clock while each byte gives at most
// one token and the receiver takes every token; a beat that gives more than
// one token (up to 3) hands them out one at a time, and input backs up once
// the four-entry token queue cannot take another three.
// When the receiver stalls, tokens wait in the queue and s_axis_tready
// drops as soon as fewer than three places would be free.
// Reset empties the queue and starts a new source at offset 0; every end
// of source also restarts the offset at 0. No clearing pass is needed.
// Depends on jts_pkg, jts_scan and jts_tok_fifo.
module json_token_scanner_top
    import jts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] src_byte
    input  logic [0:0]  s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // source_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_length
    output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
    output logic        m_axis_tlast    // last_of_run
);

    tok_batch_t batch;
    token_t     out_tok;
    logic       room;
    logic       accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    jts_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .src_byte     (s_axis_tdata),
        .byte_present (s_axis_tuser[0]),
        .source_end   (s_axis_tlast),
        .batch        (batch)
    );

    jts_tok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .batch     (batch),
        .out_ready (m_axis_tready),
        .out_tok   (out_tok),
        .out_valid (m_axis_tvalid),
        .room      (room)
    );

    assign m_axis_tdata = {out_tok.length, out_tok.start};
    assign m_axis_tuser = out_tok.kind;
    assign m_axis_tlast = out_tok.last;

endmodule

>>> rtl/jts_scan.sv
// Per-byte scanner: mode, offsets and keyword tracking, and the candidate
// tokens of each accepted beat. Depends on jts_pkg.
module jts_scan
    import jts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] src_byte,
    input  logic       byte_present,
    input  logic       source_end,
    output tok_batch_t batch
);

    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_STRING = 3'd1,
        M_INT    = 3'd2,
        M_FRAC   = 3'd3,
        M_WORD   = 3'd4
    } mode_t;

    mode_t      mode_reg, mode_next;
    pos_t       pos_reg, pos_next;
    pos_t       pstart_reg, pstart_next;
    logic [2:0] kwm_reg, kwm_next;
    logic [2:0] wlen_reg, wlen_next;

    function automatic logic is_open(mode_t m);
        return (m == M_STRING) || (m == M_INT) || (m == M_FRAC) || (m == M_WORD);
    endfunction

    function automatic tok_kind_t close_kind(mode_t m, logic [2:0] kwm, logic [2:0] wlen);
        tok_kind_t r;
        unique case (m)
            M_STRING: r = TK_STRING;
            M_INT:    r = TK_INT;
            M_FRAC:   r = TK_DOUBLE;
            M_WORD:   r = kw_kind(kwm, wlen);
            default:  r = TK_UNKNOWN;
        endcase
        return r;
    endfunction

    always_comb
    begin
        logic   do_idle;
        token_t t;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        kwm_next    = kwm_reg;
        wlen_next   = wlen_reg;
        do_idle     = 1'b0;
        t.kind      = TK_UNKNOWN;
        t.start     = '0;
        t.length    = '0;
        t.last      = 1'b0;
        batch.vld   = '0;
        for (int i = 0; i < NCAND; i++)
            batch.tok[i] = t;

        if (accept && byte_present)
        begin
            // Close an open token if this byte does not belong to it
            unique case (mode_reg)
                M_STRING:
                begin
                    if (src_byte == CH_QUOTE)
                    begin
                        batch.vld[0] = 1'b1;
                        mode_next    = M_IDLE;
                    end
                end
                M_INT:
                begin
                    if (src_byte == CH_DOT)
                        mode_next = M_FRAC;
                    else if (!is_digit(src_byte))
                    begin
                        batch.vld[0] = 1'b1;
                        do_idle      = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (!is_digit(src_byte))
                    begin
                        batch.vld[0] = 1'b1;
                        do_idle      = 1'b1;
                    end
                end
                M_WORD:
                begin
                    if (is_alpha(src_byte) || is_digit(src_byte))
                    begin
                        kwm_next  = kw_feed(kwm_reg, wlen_reg, src_byte);
                        wlen_next = (wlen_reg == 3'd7) ? wlen_reg : 3'(wlen_reg + 3'd1);
                    end
                    else
                    begin
                        batch.vld[0] = 1'b1;
                        do_idle      = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase
            batch.tok[0].kind   = close_kind(mode_reg, kwm_reg, wlen_reg);
            batch.tok[0].start  = sat16(pstart_reg);
            batch.tok[0].length = sat16(span(pos_reg, pstart_reg));

            batch.tok[1].start  = sat16(pos_reg);
            batch.tok[1].length = 16'd1;
            if (do_idle)
            begin
                mode_next = M_IDLE;
                unique case (src_byte)
                    CH_LBRACE:   begin batch.vld[1] = 1'b1; batch.tok[1].kind = TK_LBRACE;   end
                    CH_RBRACE:   begin batch.vld[1] = 1'b1; batch.tok[1].kind = TK_RBRACE;   end
                    CH_LBRACKET: begin batch.vld[1] = 1'b1; batch.tok[1].kind = TK_LBRACKET; end
                    CH_RBRACKET: begin batch.vld[1] = 1'b1; batch.tok[1].kind = TK_RBRACKET; end
                    CH_COLON:    begin batch.vld[1] = 1'b1; batch.tok[1].kind = TK_COLON;    end
                    CH_COMMA:    begin batch.vld[1] = 1'b1; batch.tok[1].kind = TK_COMMA;    end
                    CH_QUOTE:
                    begin
                        mode_next   = M_STRING;
                        pstart_next = sat_inc(pos_reg);
                    end
                    default:
                    begin
                        if (is_space(src_byte))
                            mode_next = M_IDLE;
                        else if ((src_byte == CH_MINUS) || is_digit(src_byte))
                        begin
                            mode_next   = M_INT;
                            pstart_next = pos_reg;
                        end
                        else if (is_alpha(src_byte))
                        begin
                            mode_next   = M_WORD;
                            pstart_next = pos_reg;
                            kwm_next    = kw_feed(KW_ALL, 3'd0, src_byte);
                            wlen_next   = 3'd1;
                        end
                        else
                        begin
                            batch.vld[1]      = 1'b1;
                            batch.tok[1].kind = TK_UNKNOWN;
                        end
                    end
                endcase
            end
            pos_next = sat_inc(pos_reg);
        end

        // End of source: close what is open after this byte, mark EOF, restart
        batch.tok[2].kind   = close_kind(mode_next, kwm_next, wlen_next);
        batch.tok[2].start  = sat16(pstart_next);
        batch.tok[2].length = sat16(span(pos_next, pstart_next));
        batch.tok[3].kind   = TK_EOF;
        batch.tok[3].start  = sat16(pos_next);
        if (accept && source_end)
        begin
            batch.vld[2] = is_open(mode_next);
            batch.vld[3] = 1'b1;
            mode_next    = M_IDLE;
            pos_next     = '0;
            pstart_next  = '0;
            kwm_next     = KW_ALL;
            wlen_next    = 3'd0;
        end

        for (int i = 0; i < NCAND; i++)
            batch.tok[i].last = batch.vld[i] && !(|(batch.vld >> (i + 1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            kwm_reg    <= KW_ALL;
            wlen_reg   <= 3'd0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            kwm_reg    <= kwm_next;
            wlen_reg   <= wlen_next;
        end
    end

`ifndef NO_ASSERTIONS
    logic [NCAND-1:0] last_bits;
    always_comb
    begin
        for (int i = 0; i < NCAND; i++)
            last_bits[i] = batch.tok[i].last;
    end

    a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
        (|batch.vld) |-> ($countones(last_bits & batch.vld) == 1))
        else $error("beat without exactly one final token");

    a_max_tokens: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(batch.vld) <= MAX_RESULTS)
        else $error("more tokens than one beat may give");

    a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && source_end) |=> (mode_reg == M_IDLE) && (pos_reg == '0))
        else $error("scanner not restarted after end of source");
`endif

endmodule

>>> rtl/jts_tok_fifo.sv
// Four-entry token queue: takes up to three tokens per beat, hands out one.
// Depends on jts_pkg.
module jts_tok_fifo
    import jts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tok_batch_t batch,
    input  logic       out_ready,
    output token_t     out_tok,
    output logic       out_valid,
    output logic       room
);

    token_t              mem [FIFO_DEPTH];
    logic [FIFO_CW-1:0]  count_reg, count_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  waddr [NCAND];
    logic [FIFO_CW-1:0]  npush;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign out_tok   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Take a beat only while a full burst of tokens still fits
    assign room = (FIFO_CW'(count_reg - FIFO_CW'(pop)) <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS));

    always_comb
    begin
        logic [FIFO_CW-1:0] off;
        off = '0;
        for (int i = 0; i < NCAND; i++)
        begin
            waddr[i] = FIFO_AW'(wr_ptr_reg + FIFO_AW'(off));
            off      = FIFO_CW'(off + FIFO_CW'(batch.vld[i]));
        end
        npush       = off;
        count_next  = FIFO_CW'(count_reg + npush - FIFO_CW'(pop));
        wr_ptr_next = FIFO_AW'(wr_ptr_reg + FIFO_AW'(npush));
        rd_ptr_next = FIFO_AW'(rd_ptr_reg + FIFO_AW'(pop));
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NCAND; i++)
        begin
            if (batch.vld[i])
                mem[waddr[i]] <= batch.tok[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("token queue occupancy out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (|batch.vld) |-> ((32'(count_reg) - 32'(pop) + 32'(npush)) <= FIFO_DEPTH))
        else $error("token queue overflow");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (npush == '0)) |=> (count_reg == FIFO_CW'($past(count_reg) - 1'b1)))
        else $error("token queue drain miscounted");
`endif

endmodule
